/* hdl/brf_pkg.sv */
package brf_pkg;

    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PTR_W     = ADDR_W + 1;
    localparam int DATA_W    = 8;
    localparam int REQ_W     = 3;
    localparam int COUNT_W   = 7;
    // wide enough to compare a count against a fill level without loss
    localparam int CMP_W     = PTR_W + COUNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 3'd0,
        REQ_READ    = 3'd1,
        REQ_PEEK    = 3'd2,
        REQ_DISCARD = 3'd3,
        REQ_RESET   = 3'd4
    } t_req;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_STREAM
    } t_state;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic burst_req;
        logic last_byte;
    } t_dp_status;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic emit;
    } t_dp_cmd;

endpackage

/* hdl/brf_ifs.sv */
interface brf_req_if;
    logic                          valid;
    logic                          ready;
    logic [brf_pkg::REQ_W-1:0]     req_type;
    logic [brf_pkg::DATA_W-1:0]    wr_byte;
    logic [brf_pkg::COUNT_W-1:0]   burst_len;

    modport source (output valid, req_type, wr_byte, burst_len, input ready);
    modport sink   (input valid, req_type, wr_byte, burst_len, output ready);
endinterface

interface brf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [brf_pkg::DATA_W-1:0]    rd_byte;
    logic                          byte_valid;
    logic                          last;
    logic [brf_pkg::COUNT_W-1:0]   done_count;
    logic [brf_pkg::PTR_W-1:0]     fill_level;
    logic                          is_full;
    logic                          is_empty;

    modport source (output valid, rd_byte, byte_valid, last, done_count, fill_level,
                    is_full, is_empty, input ready);
    modport sink   (input valid, rd_byte, byte_valid, last, done_count, fill_level,
                    is_full, is_empty, output ready);
endinterface

/* hdl/brf_ram.sv */
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/brf_ctrl.sv */
module brf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brf_pkg::t_dp_status i_status,
    output brf_pkg::t_dp_cmd    o_cmd
);

    brf_pkg::t_state r_state;
    brf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brf_pkg::ST_IDLE: begin
                if (i_status.in_valid && i_status.out_free && i_status.burst_req) begin
                    n_state = brf_pkg::ST_STREAM;
                end
            end
            brf_pkg::ST_STREAM: begin
                if (i_status.out_free && i_status.last_byte) begin
                    n_state = brf_pkg::ST_IDLE;
                end
            end
            default: n_state = brf_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            brf_pkg::ST_IDLE: begin
                o_cmd.in_ready = i_status.out_free;
                o_cmd.accept   = i_status.out_free && i_status.in_valid;
            end
            brf_pkg::ST_STREAM: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hdl/brf_dpath.sv */
module brf_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brf_pkg::t_dp_cmd     i_cmd,
    output brf_pkg::t_dp_status  o_status,
    brf_req_if.sink              i_req,
    brf_rsp_if.source            o_rsp
);

    logic [brf_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [brf_pkg::PTR_W-1:0]   n_wr_ptr;
    logic [brf_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [brf_pkg::PTR_W-1:0]   n_rd_ptr;
    logic [brf_pkg::PTR_W-1:0]   fill_cur;
    logic [brf_pkg::PTR_W-1:0]   fill_nxt;
    logic [brf_pkg::ADDR_W-1:0]  r_rd_addr;
    logic [brf_pkg::COUNT_W-1:0] r_left;
    logic [brf_pkg::COUNT_W-1:0] r_done;
    logic [brf_pkg::COUNT_W-1:0] lim;
    logic [brf_pkg::COUNT_W-1:0] clamp_n;
    logic [brf_pkg::COUNT_W-1:0] done_single;
    brf_pkg::t_req               req;
    logic                        full_cur;
    logic                        burst_req;
    logic                        last_byte;
    logic                        out_free;
    logic                        load_single;
    logic                        ram_we;
    logic                        ram_re;
    logic [brf_pkg::ADDR_W-1:0]  ram_raddr;
    logic [brf_pkg::DATA_W-1:0]  ram_rdata;

    logic                        r_out_valid;
    logic [brf_pkg::DATA_W-1:0]  r_rd_byte;
    logic                        r_byte_valid;
    logic                        r_last;
    logic [brf_pkg::COUNT_W-1:0] r_done_count;
    logic [brf_pkg::PTR_W-1:0]   r_fill;
    logic                        r_full;
    logic                        r_empty;

    always_comb begin
        fill_cur = r_wr_ptr - r_rd_ptr;
        full_cur = fill_cur >= brf_pkg::PTR_W'(brf_pkg::DEPTH);
        req      = brf_pkg::t_req'(i_req.req_type);
        lim      = (i_req.burst_len > brf_pkg::COUNT_W'(brf_pkg::MAX_BURST))
                 ? brf_pkg::COUNT_W'(brf_pkg::MAX_BURST) : i_req.burst_len;
        clamp_n  = (brf_pkg::CMP_W'(lim) > brf_pkg::CMP_W'(fill_cur))
                 ? brf_pkg::COUNT_W'(fill_cur) : lim;
        burst_req = (req inside {brf_pkg::REQ_READ, brf_pkg::REQ_PEEK})
                 && (clamp_n != '0);
        last_byte = r_left == brf_pkg::COUNT_W'(1);
        out_free  = !r_out_valid || o_rsp.ready;
    end

    // pointer updates happen at acceptance, so every result sees the post-request level
    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        ram_we      = 1'b0;
        done_single = '0;
        if (i_cmd.accept) begin
            case (req)
                brf_pkg::REQ_WRITE: begin
                    if (!full_cur) begin
                        ram_we      = 1'b1;
                        n_wr_ptr    = r_wr_ptr + brf_pkg::PTR_W'(1);
                        done_single = brf_pkg::COUNT_W'(1);
                    end
                end
                brf_pkg::REQ_READ, brf_pkg::REQ_DISCARD: begin
                    n_rd_ptr    = r_rd_ptr + brf_pkg::PTR_W'(clamp_n);
                    done_single = clamp_n;
                end
                brf_pkg::REQ_PEEK: begin
                    done_single = clamp_n;
                end
                brf_pkg::REQ_RESET: begin
                    n_wr_ptr = '0;
                    n_rd_ptr = '0;
                end
                default: done_single = '0;
            endcase
        end
        fill_nxt    = n_wr_ptr - n_rd_ptr;
        load_single = i_cmd.accept && !burst_req;
        ram_re      = (i_cmd.accept && burst_req) || (i_cmd.emit && !last_byte);
        ram_raddr   = i_cmd.emit ? r_rd_addr : r_rd_ptr[brf_pkg::ADDR_W-1:0];
    end

    brf_ram #(
        .WIDTH (brf_pkg::DATA_W),
        .DEPTH (brf_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr[brf_pkg::ADDR_W-1:0]),
        .i_wdata (i_req.wr_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            if (load_single || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && burst_req) begin
            r_left    <= clamp_n;
            r_done    <= clamp_n;
            r_rd_addr <= r_rd_ptr[brf_pkg::ADDR_W-1:0] + brf_pkg::ADDR_W'(1);
        end else if (i_cmd.emit) begin
            r_left    <= r_left - brf_pkg::COUNT_W'(1);
            r_rd_addr <= r_rd_addr + brf_pkg::ADDR_W'(1);
        end
        if (load_single) begin
            r_rd_byte    <= '0;
            r_byte_valid <= 1'b0;
            r_last       <= 1'b1;
            r_done_count <= done_single;
        end else if (i_cmd.emit) begin
            r_rd_byte    <= ram_rdata;
            r_byte_valid <= 1'b1;
            r_last       <= last_byte;
            r_done_count <= r_done;
        end
        if (load_single || i_cmd.emit) begin
            r_fill  <= fill_nxt;
            r_full  <= fill_nxt == brf_pkg::PTR_W'(brf_pkg::DEPTH);
            r_empty <= fill_nxt == '0;
        end
    end

    assign o_status.in_valid  = i_req.valid;
    assign o_status.out_free  = out_free;
    assign o_status.burst_req = burst_req;
    assign o_status.last_byte = last_byte;

    assign i_req.ready      = i_cmd.in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.rd_byte    = r_rd_byte;
    assign o_rsp.byte_valid = r_byte_valid;
    assign o_rsp.last       = r_last;
    assign o_rsp.done_count = r_done_count;
    assign o_rsp.fill_level = r_fill;
    assign o_rsp.is_full    = r_full;
    assign o_rsp.is_empty   = r_empty;

endmodule

/* hdl/byte_ring_fifo.sv */
// Byte FIFO over a 256-entry ring store with read and write pointers one wrap bit
// wider than the index. Each request transaction gives one or more response
// transactions, the final one flagged by last; all of them carry the fill level and
// full/empty flags as they stand after the request. Write, discard, pointer reset
// and unknown codes give one response each, so they run at one transaction per
// cycle while the response side keeps up. A read or peek of n bytes (n clamped to
// the burst limit and the fill level) is accepted and issues the first store read,
// then streams one byte per cycle out of the registered-read store while the
// response side keeps up. No request is taken mid-burst. The response register lets
// the next request be accepted in the cycle the previous response is taken. The
// store is not cleared at reset; only the pointers, output valid and state are.
module byte_ring_fifo (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brf_req_if.sink   i_req,
    brf_rsp_if.source o_rsp
);

    brf_pkg::t_dp_status status;   // datapath -> controller
    brf_pkg::t_dp_cmd    cmd;      // controller -> datapath

    // sequencer: idle / byte streaming
    brf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // pointers, clamping, ring store and response register
    brf_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_req    (i_req),
        .o_rsp    (o_rsp)
    );

endmodule

/* hdl/brf_checker.sv */
module brf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [brf_pkg::DATA_W-1:0]    i_rd_byte,
    input logic                          i_byte_valid,
    input logic                          i_last,
    input logic [brf_pkg::COUNT_W-1:0]   i_done_count,
    input logic [brf_pkg::PTR_W-1:0]     i_fill_level,
    input logic                          i_is_full,
    input logic                          i_is_empty
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rd_byte)
            && $stable(i_last) && $stable(i_fill_level))
        else $error("response changed while stalled");

    // no new request in the middle of a burst; only once the final byte is on offer
    a_no_req_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_ready && i_byte_valid && !i_last |=> i_last || !i_req_ready)
        else $error("request taken mid-burst");

    // a response without data closes its request and carries no byte
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_byte_valid |-> i_last && i_rd_byte == '0)
        else $error("dataless response not final");

    // flags agree with the level, data bursts never exceed the limit
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_is_full == (i_fill_level == brf_pkg::PTR_W'(brf_pkg::DEPTH)))
            && (i_is_empty == (i_fill_level == '0))
            && (!i_byte_valid || (i_done_count != '0
                && i_done_count <= brf_pkg::COUNT_W'(brf_pkg::MAX_BURST))))
        else $error("status flags or count inconsistent");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rd_byte    (o_rsp.rd_byte),
    .i_byte_valid (o_rsp.byte_valid),
    .i_last       (o_rsp.last),
    .i_done_count (o_rsp.done_count),
    .i_fill_level (o_rsp.fill_level),
    .i_is_full    (o_rsp.is_full),
    .i_is_empty   (o_rsp.is_empty)
);
